/* rtl/core/assert_macros.svh */
// assertion macros used by zip_central_directory_parser.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/cdp_pkg.sv */
// types and constants of the central directory parser
`timescale 1ns / 1ps
package cdp_pkg;

    localparam logic [31:0] CD_SIGNATURE   = 32'h0201_4b50;
    localparam logic [31:0] SENTINEL32     = 32'hFFFF_FFFF;
    localparam logic [15:0] ZIP64_TAG      = 16'h0001;

    // byte positions in the fixed header
    localparam logic [15:0] SIG_LAST        = 16'd3;
    localparam logic [15:0] CSIZE_LAST      = 16'd23;
    localparam logic [15:0] USIZE_LAST      = 16'd27;
    localparam logic [15:0] NAME_LEN_LAST   = 16'd29;
    localparam logic [15:0] EXTRA_LEN_LAST  = 16'd31;
    localparam logic [15:0] COMMENT_LEN_LAST = 16'd33;
    localparam logic [15:0] HEADER_LAST     = 16'd45;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_EXTRA   = 5'b00100,
        PH_COMMENT = 5'b01000,
        PH_HALTED  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        has_name_byte;
        logic [7:0]  name_out;
        logic        entry_done;
        logic        bad_signature;
        logic [63:0] header_offset;
        logic [31:0] entry_number;
        logic [15:0] name_length;
    } result_t;

endpackage

/* rtl/core/cdp_in_stage.sv */
// input register holding one byte item
`timescale 1ns / 1ps
module cdp_in_stage
    import cdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            byte_next  = data_byte;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

/* rtl/core/cdp_parser.sv */
// record parser state and per-byte next-state logic
`timescale 1ns / 1ps
module cdp_parser
    import cdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic [31:0] total_entries,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] phase_count_reg, phase_count_next;
    logic [31:0] signature_shift_reg, signature_shift_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [15:0] comment_len_reg, comment_len_next;
    logic [1:0]  size_sentinels_reg, size_sentinels_next;
    logic [63:0] offset_reg, offset_next;
    logic [31:0] tag_header_reg, tag_header_next;
    logic [15:0] tag_cursor_reg, tag_cursor_next;
    logic [16:0] capture_position_reg, capture_position_next;
    logic        extra_scan_on_reg, extra_scan_on_next;
    logic [31:0] entries_seen_reg, entries_seen_next;

    logic        active;
    logic        done;
    logic        bad;
    logic [31:0] sig_shift;
    logic [16:0] idx17;
    logic        part_last;
    logic [15:0] part_len;
    logic        cap_hit;
    logic [2:0]  cap_k;
    logic        tag_hit;
    logic        tag_last;
    logic [31:0] tag_new;
    logic [16:0] tag_start;
    logic [17:0] tag_end;
    logic [18:0] f0, f1, f2;
    logic [63:0] offset_ins;

    assign active    = (phase_reg != PH_HALTED) && (entries_seen_reg < total_entries);
    assign sig_shift = {data_byte, signature_shift_reg[31:8]};
    assign idx17     = {1'b0, phase_count_reg};

    always_comb
    begin
        unique case (phase_reg)
            PH_NAME:  part_len = name_len_reg;
            PH_EXTRA: part_len = extra_len_reg;
            default:  part_len = comment_len_reg;
        endcase
    end

    assign part_last = (idx17 + 17'd1) >= {1'b0, part_len};

    // extra field walk
    assign cap_hit  = (idx17 >= capture_position_reg)
                      && ({1'b0, idx17} < ({1'b0, capture_position_reg} + 18'd8));
    assign cap_k    = 3'(idx17 - capture_position_reg);
    assign tag_hit  = (phase_count_reg >= tag_cursor_reg)
                      && (idx17 < ({1'b0, tag_cursor_reg} + 17'd4));
    assign tag_last = idx17 == ({1'b0, tag_cursor_reg} + 17'd3);
    assign tag_new  = {data_byte, tag_header_reg[31:8]};
    assign tag_start = {1'b0, tag_cursor_reg} + 17'd4;
    assign tag_end   = {1'b0, tag_start} + {2'b00, tag_new[31:16]};
    assign f0 = {2'b00, tag_start};
    assign f1 = (size_sentinels_reg[1] && (f0 + 19'd8 <= {1'b0, tag_end})) ? f0 + 19'd8 : f0;
    assign f2 = (size_sentinels_reg[0] && (f1 + 19'd8 <= {1'b0, tag_end})) ? f1 + 19'd8 : f1;
    assign offset_ins = ((cap_k == 3'd0) ? 64'd0 : offset_reg)
                        | ({56'd0, data_byte} << {cap_k, 3'b000});

    always_comb
    begin
        phase_next            = phase_reg;
        phase_count_next      = phase_count_reg;
        signature_shift_next  = signature_shift_reg;
        name_len_next         = name_len_reg;
        extra_len_next        = extra_len_reg;
        comment_len_next      = comment_len_reg;
        size_sentinels_next   = size_sentinels_reg;
        offset_next           = offset_reg;
        tag_header_next       = tag_header_reg;
        tag_cursor_next       = tag_cursor_reg;
        capture_position_next = capture_position_reg;
        extra_scan_on_next    = extra_scan_on_reg;
        entries_seen_next     = entries_seen_reg;
        done                  = 1'b0;
        bad                   = 1'b0;
        res                   = '0;

        if (active)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    signature_shift_next = sig_shift;
                    if (phase_count_reg == SIG_LAST && sig_shift != CD_SIGNATURE)
                    begin
                        phase_next = PH_HALTED;
                        bad        = 1'b1;
                    end
                    else
                    begin
                        if (phase_count_reg == CSIZE_LAST && sig_shift == SENTINEL32)
                            size_sentinels_next[0] = 1'b1;
                        if (phase_count_reg == USIZE_LAST && sig_shift == SENTINEL32)
                            size_sentinels_next[1] = 1'b1;
                        if (phase_count_reg == NAME_LEN_LAST)
                            name_len_next = sig_shift[31:16];
                        if (phase_count_reg == EXTRA_LEN_LAST)
                            extra_len_next = sig_shift[31:16];
                        if (phase_count_reg == COMMENT_LEN_LAST)
                            comment_len_next = sig_shift[31:16];
                        if (phase_count_reg == HEADER_LAST)
                        begin
                            offset_next           = {32'd0, sig_shift};
                            extra_scan_on_next    = sig_shift == SENTINEL32;
                            tag_cursor_next       = '0;
                            tag_header_next       = '0;
                            capture_position_next = '0;
                            phase_count_next      = '0;
                            priority if (name_len_reg != 16'd0)
                                phase_next = PH_NAME;
                            else if (extra_len_reg != 16'd0)
                                phase_next = PH_EXTRA;
                            else if (comment_len_reg != 16'd0)
                                phase_next = PH_COMMENT;
                            else
                                done = 1'b1;
                        end
                        else
                        begin
                            phase_count_next = phase_count_reg + 16'd1;
                        end
                    end
                end
                PH_NAME:
                begin
                    res.has_name_byte = 1'b1;
                    res.name_out      = data_byte;
                    if (part_last)
                    begin
                        phase_count_next = '0;
                        priority if (extra_len_reg != 16'd0)
                            phase_next = PH_EXTRA;
                        else if (comment_len_reg != 16'd0)
                            phase_next = PH_COMMENT;
                        else
                            done = 1'b1;
                    end
                    else
                    begin
                        phase_count_next = phase_count_reg + 16'd1;
                    end
                end
                PH_EXTRA:
                begin
                    if (extra_scan_on_reg)
                    begin
                        if (capture_position_reg != 17'd0)
                        begin
                            if (cap_hit)
                            begin
                                offset_next = offset_ins;
                                if (cap_k == 3'd7)
                                    extra_scan_on_next = 1'b0;
                            end
                        end
                        else if (tag_hit)
                        begin
                            tag_header_next = tag_new;
                            if (tag_last)
                            begin
                                priority if (tag_end > {2'b00, extra_len_reg})
                                    extra_scan_on_next = 1'b0;
                                else if (tag_new[15:0] == ZIP64_TAG)
                                begin
                                    if (f2 + 19'd8 <= {1'b0, tag_end})
                                        capture_position_next = f2[16:0];
                                    else
                                        extra_scan_on_next = 1'b0;
                                end
                                else
                                    tag_cursor_next = tag_end[15:0];
                            end
                        end
                    end
                    if (part_last)
                    begin
                        phase_count_next = '0;
                        if (comment_len_reg != 16'd0)
                            phase_next = PH_COMMENT;
                        else
                            done = 1'b1;
                    end
                    else
                    begin
                        phase_count_next = phase_count_reg + 16'd1;
                    end
                end
                PH_COMMENT:
                begin
                    if (part_last)
                        done = 1'b1;
                    else
                        phase_count_next = phase_count_reg + 16'd1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            res.bad_signature = bad;
            if (done)
            begin
                res.entry_done    = 1'b1;
                res.header_offset = offset_next;
                res.entry_number  = entries_seen_reg;
                res.name_length   = name_len_reg;
                entries_seen_next     = entries_seen_reg + 32'd1;
                phase_next            = PH_HEADER;
                phase_count_next      = '0;
                size_sentinels_next   = '0;
                extra_scan_on_next    = 1'b0;
                capture_position_next = '0;
                tag_cursor_next       = '0;
                tag_header_next       = '0;
            end
        end
    end

    assign res_valid = res.has_name_byte || res.entry_done || res.bad_signature;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            phase_count_reg      <= '0;
            signature_shift_reg  <= '0;
            name_len_reg         <= '0;
            extra_len_reg        <= '0;
            comment_len_reg      <= '0;
            size_sentinels_reg   <= '0;
            offset_reg           <= '0;
            tag_header_reg       <= '0;
            tag_cursor_reg       <= '0;
            capture_position_reg <= '0;
            extra_scan_on_reg    <= 1'b0;
            entries_seen_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg            <= phase_next;
            phase_count_reg      <= phase_count_next;
            signature_shift_reg  <= signature_shift_next;
            name_len_reg         <= name_len_next;
            extra_len_reg        <= extra_len_next;
            comment_len_reg      <= comment_len_next;
            size_sentinels_reg   <= size_sentinels_next;
            offset_reg           <= offset_next;
            tag_header_reg       <= tag_header_next;
            tag_cursor_reg       <= tag_cursor_next;
            capture_position_reg <= capture_position_next;
            extra_scan_on_reg    <= extra_scan_on_next;
            entries_seen_reg     <= entries_seen_next;
        end
    end

endmodule

/* rtl/core/cdp_out_stage.sv */
// result register toward the output channel
`timescale 1ns / 1ps
module cdp_out_stage
    import cdp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s1_valid,
    input  logic    res_valid,
    input  result_t res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance)
        begin
            valid_next = s1_valid && res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* rtl/core/zip_central_directory_parser.sv */
// top level of the zip central directory record parser
//
//  channel   signals                          dir   payload
//  ------------------------------------------------------------------------
//  input     in_valid / in_ready              in    data_byte
//  output    out_valid / out_ready            out   name byte, record result
//  config    cfg_valid / cfg_ready            in    cfg_data (total_entries)
//
// one byte item per cycle unless the output stalls
// each byte updates the parser state in one pass between input and result register
// an item that gives no result leaves no entry at the output
// a stalled output holds the input register, which then holds in_ready low
// reset sets the parser phase to PH_HEADER and clears its other state and total_entries to zero
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zip_central_directory_parser
    import cdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        has_name_byte,
    output logic [7:0]  name_out,
    output logic        entry_done,
    output logic        bad_signature,
    output logic [63:0] header_offset,
    output logic [31:0] entry_number,
    output logic [15:0] name_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] total_entries_reg;
    logic        s1_valid;
    logic [7:0]  s1_byte;
    logic        advance;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_entries_reg <= '0;
        else if (cfg_valid && cfg_ready)
            total_entries_reg <= cfg_data;
    end

    cdp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte)
    );

    cdp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (s1_valid && advance),
        .data_byte     (s1_byte),
        .total_entries (total_entries_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    cdp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign has_name_byte = out_res.has_name_byte;
    assign name_out      = out_res.name_out;
    assign entry_done    = out_res.entry_done;
    assign bad_signature = out_res.bad_signature;
    assign header_offset = out_res.header_offset;
    assign entry_number  = out_res.entry_number;
    assign name_length   = out_res.name_length;

    `ASSERT_NEXT(a_stalled_byte_held, clk, rst_n, s1_valid && !advance, s1_valid && $stable(s1_byte))
    `ASSERT_IMPLIES(a_result_not_empty, clk, rst_n, out_valid, has_name_byte || entry_done || bad_signature)
    `ASSERT_IMPLIES(a_bad_sig_alone, clk, rst_n, out_valid && bad_signature, !entry_done && !has_name_byte)

endmodule
